// ===== sv/tea_pkg.sv =====
package tea_pkg;

  // round constant and default round count
  localparam logic [31:0] TEA_DELTA      = 32'h9e37_79b9;
  localparam int unsigned ROUNDS_DEFAULT = 32;

  // configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] left_word;
    logic [31:0] right_word;
  } req_beat_t;

  typedef struct packed {
    logic [31:0] left_result;
    logic [31:0] right_result;
  } rsp_beat_t;

  // data carried from stage to stage
  typedef struct packed {
    logic        op;
    logic [31:0] y;
    logic [31:0] z;
  } stage_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  // tea feistel mixing term
  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

// ===== sv/tea_cfg_regs.sv =====
module tea_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tea_pkg::PADDR_W-1:0]   paddr,
  input  logic [tea_pkg::PDATA_W-1:0]   pwdata,
  output logic [tea_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tea_pkg::key_t                 key
);
  import tea_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // key word registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_KEY0: key.k0 <= pwdata;
        REG_KEY1: key.k1 <= pwdata;
        REG_KEY2: key.k2 <= pwdata;
        REG_KEY3: key.k3 <= pwdata;
        default:  key    <= key;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_KEY0: prdata = key.k0;
      REG_KEY1: prdata = key.k1;
      REG_KEY2: prdata = key.k2;
      REG_KEY3: prdata = key.k3;
      default:  prdata = '0;
    endcase
  end

endmodule

// ===== sv/tea_round_stage.sv =====
module tea_round_stage #(
  parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT,
  parameter int unsigned STAGE  = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  tea_pkg::key_t   key,
  input  logic            up_valid,
  output logic            up_ready,
  input  tea_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tea_pkg::stage_t dn_data
);
  import tea_pkg::*;

  // each stage is one half round; the round sum is fixed per stage
  localparam int unsigned RND       = STAGE / 2;
  localparam bit          EVEN      = (STAGE % 2) == 0;
  localparam logic [63:0] ENC_SUM64 = 64'(TEA_DELTA) * 64'(RND + 1);
  localparam logic [63:0] DEC_SUM64 = 64'(TEA_DELTA) * 64'(ROUNDS - RND);
  localparam logic [31:0] ENC_SUM   = ENC_SUM64[31:0];
  localparam logic [31:0] DEC_SUM   = DEC_SUM64[31:0];

  logic        upd_y;
  logic [31:0] v, sum, ka, kb, tgt, m, res;
  stage_t      nxt;
  logic        valid;

  // half-round datapath
  always_comb begin
    upd_y = EVEN ^ (up_data.op == OP_DECRYPT);
    v     = upd_y ? up_data.z : up_data.y;
    tgt   = upd_y ? up_data.y : up_data.z;
    ka    = upd_y ? key.k0 : key.k2;
    kb    = upd_y ? key.k1 : key.k3;
    sum   = (up_data.op == OP_DECRYPT) ? DEC_SUM : ENC_SUM;
    m     = tea_mix(v, sum, ka, kb);
    res   = (up_data.op == OP_DECRYPT) ? (tgt - m) : (tgt + m);
    nxt   = up_data;
    if (upd_y) begin
      nxt.y = res;
    end else begin
      nxt.z = res;
    end
  end

  // stage takes a beat when empty or when its beat moves on
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

  assign dn_valid = valid;

endmodule

// ===== sv/tea_block_cipher.sv =====
// channel  | signals                   | direction | payload
// ---------+---------------------------+-----------+--------------------------------
// req      | req_valid / req_ready     | in        | operation, left_word, right_word
// rsp      | rsp_valid / rsp_ready     | out       | left_result, right_result
// apb      | psel/penable/pwrite/pready| in/out    | key words 0..3 at 0x0..0xc
//
// one beat per cycle in and out while rsp_ready is high;
// one register stage per half round, each with one mix and one add or subtract.
// reset clears all stage valid bits and the key words.
// each stage holds its beat while the next one is full and stalled, so a
// stalled output still lets beats enter until the empty stages are filled.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  tea_pkg::req_beat_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output tea_pkg::rsp_beat_t          rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tea_pkg::PADDR_W-1:0] paddr,
  input  logic [tea_pkg::PDATA_W-1:0] pwdata,
  output logic [tea_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tea_pkg::*;

  localparam int unsigned NSTAGE = 2 * ROUNDS;

  key_t   key;
  stage_t stage_data  [0:NSTAGE];
  logic   stage_valid [0:NSTAGE];
  logic   stage_ready [0:NSTAGE];

  // key registers
  tea_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  // pipeline entry
  assign stage_valid[0]   = req_valid;
  assign stage_data[0].op = req.operation;
  assign stage_data[0].y  = req.left_word;
  assign stage_data[0].z  = req.right_word;
  assign req_ready        = stage_ready[0];

  // half-round stages
  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    tea_round_stage #(
      .ROUNDS (ROUNDS),
      .STAGE  (s)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .up_valid (stage_valid[s]),
      .up_ready (stage_ready[s]),
      .up_data  (stage_data[s]),
      .dn_valid (stage_valid[s+1]),
      .dn_ready (stage_ready[s+1]),
      .dn_data  (stage_data[s+1])
    );
  end

  // last stage register is the output register
  assign rsp_valid           = stage_valid[NSTAGE];
  assign stage_ready[NSTAGE] = rsp_ready;
  assign rsp.left_result     = stage_data[NSTAGE].y;
  assign rsp.right_result    = stage_data[NSTAGE].z;

  // key word 0 write lands in the register
  a_key0_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && reg_idx_t'(paddr[3:2]) == REG_KEY0)
      |=> (key.k0 == $past(pwdata)))
    else $error("key word 0 write lost");

  // an empty first stage always takes a beat
  a_first_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid[1] |-> req_ready)
    else $error("input stalled with empty first stage");

  // nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule
